### hdl/swr_pkg.sv
// Shared types and constants for the stream word replace block.
// Used by the front, queue, back and top-level modules.
package swr_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 64;
  localparam int LEN_W       = 4;
  localparam int MAX_BYTES   = 8;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_WORD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_WORD   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH = CFG_IDX_W'(3);

  // One emit job: up to eight words packed low byte first, a count and an end flag.
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [LEN_W-1:0]  count;
    logic              last;
  } job_t;

endpackage

### hdl/swr_front.sv
// Front part: configuration registers, pending prefix and match classification.
// Depends on swr_pkg; produces at most one emit job per accepted word.
module swr_front #(
  parameter int MAX_WORD_BYTES = swr_pkg::MAX_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swr_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swr_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          end_of_text,
  input  logic                          queue_full,
  output logic                          push,
  output swr_pkg::job_t                 job
);
  import swr_pkg::*;

  localparam int PCW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_WORD_BYTES);

  logic [WORD_W-1:0] search_word;
  logic [LEN_W-1:0]  search_length;
  logic [WORD_W-1:0] replace_word;
  logic [LEN_W-1:0]  replace_length;

  logic [BYTE_W-1:0] pending [MAX_WORD_BYTES];
  logic [BYTE_W-1:0] pending_next [MAX_WORD_BYTES];
  logic [PCW-1:0]    pending_count;
  logic [PCW-1:0]    pending_count_next;

  logic [LEN_W-1:0] slen;
  logic [LEN_W-1:0] rlen;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] start;
  logic [LEN_W-1:0] rem;
  logic [2*MAX_WORD_BYTES*BYTE_W-1:0] win;
  logic [MAX_WORD_BYTES-1:0] can_start;
  logic full_match;
  logic accept;
  logic cfg_write;
  logic search_write;

  assign cfg_ready    = 1'b1;
  assign cfg_write    = cfg_valid && cfg_ready;
  assign search_write = cfg_write &&
                        (cfg_index == CFG_SEARCH_WORD || cfg_index == CFG_SEARCH_LENGTH);
  assign in_ready     = !queue_full;
  assign accept       = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_word    <= '0;
      search_length  <= LEN_W'(1);
      replace_word   <= '0;
      replace_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEARCH_WORD:    search_word    <= cfg_data;
        CFG_SEARCH_LENGTH:  search_length  <= cfg_data[LEN_W-1:0];
        CFG_REPLACE_WORD:   replace_word   <= cfg_data;
        CFG_REPLACE_LENGTH: replace_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective lengths, clamped to the supported range.
  always_comb begin
    if (search_length == '0) begin
      slen = LEN_W'(1);
    end else if (search_length > MAXL) begin
      slen = MAXL;
    end else begin
      slen = search_length;
    end
    rlen = (replace_length > MAXL) ? MAXL : replace_length;
    n    = LEN_W'(pending_count) + LEN_W'(1);
  end

  // The window is the pending prefix followed by the new word, zero padded.
  always_comb begin
    win = '0;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if (i < int'(pending_count)) begin
        win[i*BYTE_W +: BYTE_W] = pending[i];
      end else if (i == int'(pending_count)) begin
        win[i*BYTE_W +: BYTE_W] = in_byte;
      end
    end
  end

  // Full match of the search word over the whole window.
  always_comb begin
    full_match = (n == slen);
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if (i < int'(n) && win[i*BYTE_W +: BYTE_W] != search_word[i*BYTE_W +: BYTE_W]) begin
        full_match = 1'b0;
      end
    end
  end

  // A position may still begin a match if its tail is a proper prefix of the search word.
  always_comb begin
    for (int s = 0; s < MAX_WORD_BYTES; s++) begin
      can_start[s] = (s < int'(n)) && ((int'(n) - s) < int'(slen));
      for (int j = 0; j < MAX_WORD_BYTES; j++) begin
        if ((s + j) < int'(n) &&
            win[(s+j)*BYTE_W +: BYTE_W] != search_word[j*BYTE_W +: BYTE_W]) begin
          can_start[s] = 1'b0;
        end
      end
    end
  end

  // Leftmost position that may begin a match; the window length if none.
  always_comb begin
    start = n;
    for (int s = MAX_WORD_BYTES - 1; s >= 0; s--) begin
      if (can_start[s]) begin
        start = LEN_W'(s);
      end
    end
  end

  // Build the emit job and the next pending prefix.
  always_comb begin
    job.last = end_of_text;
    if (full_match) begin
      job.data  = replace_word;
      job.count = rlen;
      rem       = '0;
    end else begin
      job.data  = WORD_W'(win[MAX_WORD_BYTES*BYTE_W-1:0]);
      job.count = end_of_text ? n : start;
      rem       = end_of_text ? '0 : (n - start);
    end
    pending_count_next = PCW'(rem);
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      pending_next[i] = win[(int'(start) + i)*BYTE_W +: BYTE_W];
    end
  end

  // Jobs with nothing to emit and no end of text are dropped here.
  assign push = accept && (job.count != '0 || job.last);

  // Pending prefix storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
    end else if (search_write) begin
      pending_count <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= pending_next;
    end
  end

  // The pending bytes always stay shorter than the search word.
  a_pending_short: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(pending_count) < slen)
    else $error("pending prefix not shorter than search word");

endmodule

### hdl/swr_queue.sv
// Short job queue between the front and back parts.
// Depends on swr_pkg for the job type.
module swr_queue #(
  parameter int DEPTH = swr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  swr_pkg::job_t push_job,
  input  logic          pop,
  output swr_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import swr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;

  assign empty = (level == '0);
  assign full  = (level == LW'(DEPTH));
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("job queue underflow");

endmodule

### hdl/swr_back.sv
// Back part: walks each queued job and emits its words one per cycle while out_ready does not stall it.
// Depends on swr_pkg; drives the registered output channel.
module swr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  swr_pkg::job_t              head,
  input  logic                       queue_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [swr_pkg::BYTE_W-1:0] out_byte,
  output logic                       byte_valid,
  output logic                       last
);
  import swr_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             final_word;

  // Load the output register whenever a job waits and the register is free or being drained.
  assign load       = !queue_empty && (!out_valid || out_ready);
  assign final_word = (head.count == '0) || (LEN_W'(idx) == head.count - LEN_W'(1));
  assign pop        = load && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_word ? '0 : idx + IDX_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; an empty job becomes the empty end marker.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= (head.count == '0) ? '0 : head.data[int'(idx)*BYTE_W +: BYTE_W];
      byte_valid <= (head.count != '0);
      last       <= head.last && final_word;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("empty marker without last");
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !queue_empty |-> (head.count == '0 && idx == '0) || LEN_W'(idx) < head.count)
    else $error("word index beyond job count");

endmodule

### hdl/stream_word_replace_core.sv
// Top level of the stream word replace block.
// Depends on swr_pkg, swr_front, swr_queue and swr_back.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//   in      | in_valid / in_ready    | in_byte, end_of_text
//   out     | out_valid / out_ready  | out_byte, byte_valid, last
//
// One word is accepted per cycle while the job queue has room; classification
// happens in the cycle of acceptance. The back part emits one output word per
// cycle while the receiver is ready, and the input stalls only once the
// four-entry queue fills. The first output word is written to a queue entry and
// then loaded into the output register before it is presented. Reset is
// synchronous and clears the queue, the pending count and the registers; there
// is no clearing pass.
module stream_word_replace_core #(
  parameter int MAX_WORD_BYTES = swr_pkg::MAX_BYTES,
  parameter int QUEUE_DEPTH    = swr_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swr_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swr_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swr_pkg::BYTE_W-1:0]    out_byte,
  output logic                          byte_valid,
  output logic                          last
);
  import swr_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_empty;
  logic queue_full;

  // Classification and pending prefix.
  swr_front #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  // Job queue between the two sides.
  swr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(front_job),
    .pop     (pop),
    .head    (head_job),
    .empty   (queue_empty),
    .full    (queue_full)
  );

  // Word serializer and output register.
  swr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .queue_empty(queue_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last)
  );

endmodule

### bench/tb_top.sv
// Self-checking testbench for stream_word_replace_core: directed and random texts.
// Depends on swr_pkg and the stream_word_replace_core RTL; nothing else is needed.
`timescale 1ns / 100ps

module tb_top;
  import swr_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

  // One expected output word of the rewritten text.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              ch_valid;
    logic              fin;
  } out_word_t;

  // An index outside the register list; a write there changes nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(5);
  localparam int unsigned RANDOM_ITEMS = 360;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [BYTE_W-1:0] in_byte;
  logic end_of_text;
  logic out_valid;
  logic out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic byte_valid;
  logic last;

  // Register copies and held text bytes of the predictor.
  logic [WORD_W-1:0] m_search_word;
  logic [LEN_W-1:0] m_search_len;
  logic [WORD_W-1:0] m_replace_word;
  logic [LEN_W-1:0] m_replace_len;
  logic [WORD_W-1:0] held_bytes;
  int unsigned held_n;

  out_word_t rewritten_q[$];
  out_word_t head_w;
  logic [BYTE_W-1:0] text_buf[$];
  int unsigned mismatch_count = 0;
  idle_mode_t src_idle = IDLE_NONE;
  idle_mode_t sink_idle = IDLE_NONE;
  int unsigned sink_hold = 0;

  stream_word_replace_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap in cycles before the next word on either side.
  function automatic int unsigned draw_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      default:   return $urandom_range(0, 13);
    endcase
  endfunction

  // Search length as the block uses it: 0 acts as 1, large values as the maximum.
  function automatic int unsigned search_span();
    if (m_search_len == 0) return 1;
    if (m_search_len > MAX_BYTES) return MAX_BYTES;
    return m_search_len;
  endfunction

  function automatic int unsigned replace_span();
    if (m_replace_len > MAX_BYTES) return MAX_BYTES;
    return m_replace_len;
  endfunction

  // True if len bytes of the window starting at pos equal the search word head.
  function automatic logic is_search_prefix(input logic [WORD_W-1:0] win,
                                            input int unsigned pos, input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++)
      if (win[8*(pos+i) +: 8] != m_search_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Rewrites one accepted text byte and queues the output words it produces.
  function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic eot);
    logic [WORD_W-1:0] win;
    logic [BYTE_W-1:0] outs [0:MAX_BYTES];
    int unsigned slen, rlen, n, start, count, i;
    out_word_t w;
    slen = search_span();
    rlen = replace_span();
    win = '0;
    n = held_n;
    for (i = 0; i < n; i++) win[8*i +: 8] = held_bytes[8*i +: 8];
    win[8*n +: 8] = b;
    n++;
    start = 0;
    count = 0;
    if (n == slen && is_search_prefix(win, 0, n)) begin
      for (i = 0; i < rlen; i++) begin
        outs[count] = m_replace_word[8*i +: 8];
        count++;
      end
      start = n;
    end else begin
      // A byte passes once no occurrence can start at it.
      while (start < n) begin
        if (n - start < slen && is_search_prefix(win, start, n - start)) break;
        outs[count] = win[8*start +: 8];
        count++;
        start++;
      end
    end
    if (eot) begin
      while (start < n) begin
        outs[count] = win[8*start +: 8];
        count++;
        start++;
      end
      held_n = 0;
    end else begin
      held_n = n - start;
      for (i = 0; i < held_n; i++) held_bytes[8*i +: 8] = win[8*(start+i) +: 8];
    end
    for (i = 0; i < count; i++) begin
      w.ch = outs[i];
      w.ch_valid = 1'b1;
      w.fin = eot && (i == count - 1);
      rewritten_q.push_back(w);
    end
    // An end of text that emits nothing still closes the text with an empty word.
    if (eot && count == 0) begin
      w.ch = '0;
      w.ch_valid = 1'b0;
      w.fin = 1'b1;
      rewritten_q.push_back(w);
    end
  endfunction

  // Eight random bytes, from a three-letter alphabet when asked.
  function automatic logic [WORD_W-1:0] random_word(input logic alpha);
    logic [WORD_W-1:0] w;
    int unsigned i;
    for (i = 0; i < MAX_BYTES; i++)
      w[8*i +: 8] = alpha ? 8'h61 + BYTE_W'($urandom_range(0, 2)) : BYTE_W'($urandom_range(0, 255));
    return w;
  endfunction

  // Length value in the low nibble, random bits above it.
  function automatic logic [WORD_W-1:0] length_data(input int unsigned len);
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = LEN_W'(len);
    return w;
  endfunction

  function automatic int unsigned random_search_len();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 4);
    if (pick < 17) return $urandom_range(5, 8);
    pick = $urandom_range(0, 7);
    return (pick == 0) ? 0 : 8 + pick;
  endfunction

  function automatic int unsigned random_replace_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 15);
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("ERROR at %0t ns: %s, got %0h, expected %0h", $time, what, got, want);
  endtask

  // Writes one register; called at a falling edge while the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_SEARCH_WORD: begin
        m_search_word = val;
        held_n = 0;
      end
      CFG_SEARCH_LENGTH: begin
        m_search_len = val[LEN_W-1:0];
        held_n = 0;
      end
      CFG_REPLACE_WORD: m_replace_word = val;
      CFG_REPLACE_LENGTH: m_replace_len = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one text byte and predicts its output once it is taken.
  task automatic send_char(input logic [BYTE_W-1:0] b, input logic eot);
    int unsigned gap;
    gap = draw_gap(src_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte <= b;
    end_of_text <= eot;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    rewrite_byte(b, eot);
    @(negedge clk);
  endtask

  // Drops valid after the last word of a burst.
  task automatic source_rest();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], eot_last && (i == s.len() - 1));
    source_rest();
  endtask

  // Waits for every expected word, then lets the block settle.
  task automatic wait_drained();
    while (rewritten_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Reset registers: the search word is one zero byte, replaced by nothing.
  task automatic test_reset_values();
    send_char(8'h00, 1'b1);
    source_rest();
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    source_rest();
    wait_drained();
  endtask

  // A two-byte search, a longer replacement, and a search change in mid-text.
  task automatic test_basic_replace();
    cfg_write(CFG_SEARCH_WORD, 64'h6261);
    cfg_write(CFG_SEARCH_LENGTH, length_data(2));
    cfg_write(CFG_REPLACE_WORD, 64'h5A5958);
    cfg_write(CFG_REPLACE_LENGTH, length_data(3));
    cfg_write(CFG_UNUSED, '1);
    send_string("aaba", 1'b1);
    wait_drained();
    // The held byte is dropped when the search length is rewritten.
    send_string("a", 1'b0);
    wait_drained();
    cfg_write(CFG_SEARCH_LENGTH, length_data(2));
    send_string("b", 1'b1);
    wait_drained();
    // Same for a rewrite of the search word.
    send_string("a", 1'b0);
    wait_drained();
    cfg_write(CFG_SEARCH_WORD, 64'h6261);
    send_string("b", 1'b1);
    wait_drained();
  endtask

  // Out-of-range lengths and the widest words.
  task automatic test_length_limits();
    logic [WORD_W-1:0] pat;
    int i;
    pat = 64'h00FF_7E81_5AA5_01FE;
    cfg_write(CFG_SEARCH_WORD, 64'hFF);
    cfg_write(CFG_SEARCH_LENGTH, length_data(0));
    cfg_write(CFG_REPLACE_WORD, 64'h0123_4567_89AB_CDEF);
    cfg_write(CFG_REPLACE_LENGTH, length_data(15));
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    source_rest();
    wait_drained();
    // Eight-byte match deleted at end of text leaves only the empty end word.
    cfg_write(CFG_SEARCH_WORD, pat);
    cfg_write(CFG_SEARCH_LENGTH, length_data(15));
    cfg_write(CFG_REPLACE_LENGTH, length_data(0));
    for (i = 0; i < MAX_BYTES; i++) send_char(pat[8*i +: 8], i == MAX_BYTES - 1);
    source_rest();
    wait_drained();
  endtask

  // Receiver holds off while bytes that expand eightfold keep coming,
  // then the sender stops in mid-text until the output is drained.
  task automatic test_backpressure();
    int i;
    cfg_write(CFG_SEARCH_WORD, 64'h61);
    cfg_write(CFG_SEARCH_LENGTH, length_data(1));
    cfg_write(CFG_REPLACE_WORD, random_word(1'b0));
    cfg_write(CFG_REPLACE_LENGTH, length_data(8));
    src_idle = IDLE_NONE;
    sink_idle = IDLE_NONE;
    sink_hold = 150;
    for (i = 0; i < 24; i++)
      send_char(($urandom_range(0, 3) != 0) ? 8'h61 : BYTE_W'($urandom_range(0, 255)), i == 23);
    source_rest();
    wait_drained();
    cfg_write(CFG_SEARCH_WORD, random_word(1'b1));
    cfg_write(CFG_SEARCH_LENGTH, length_data(3));
    cfg_write(CFG_REPLACE_LENGTH, length_data(2));
    src_idle = IDLE_SOME;
    sink_idle = IDLE_SOME;
    for (i = 0; i < 10; i++) send_char(8'h61 + BYTE_W'($urandom_range(0, 2)), 1'b0);
    source_rest();
    wait_drained();
    for (i = 0; i < 10; i++) send_char(8'h61 + BYTE_W'($urandom_range(0, 2)), i == 9);
    source_rest();
    wait_drained();
  endtask

  // Random settings and texts built mostly from pieces of the search word.
  task automatic test_random_texts();
    int unsigned sent, target, pick, k, i, slen;
    logic alpha;
    logic [CFG_IDX_W-1:0] idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle = idle_mode_t'($urandom_range(0, 2));
      sink_idle = idle_mode_t'($urandom_range(0, 2));
      alpha = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) cfg_write(CFG_SEARCH_WORD, random_word(alpha));
      if ($urandom_range(0, 2) != 0) cfg_write(CFG_SEARCH_LENGTH, length_data(random_search_len()));
      if ($urandom_range(0, 2) != 0) cfg_write(CFG_REPLACE_WORD, random_word(1'b0));
      if ($urandom_range(0, 2) != 0)
        cfg_write(CFG_REPLACE_LENGTH, length_data(random_replace_len()));

      // Build the text: whole words, word prefixes and stray bytes.
      slen = search_span();
      text_buf = {};
      target = $urandom_range(1, 24);
      while (text_buf.size() < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          for (i = 0; i < slen; i++) text_buf.push_back(m_search_word[8*i +: 8]);
        end else if (pick < 6) begin
          k = $urandom_range(1, slen);
          for (i = 0; i < k; i++) text_buf.push_back(m_search_word[8*i +: 8]);
        end else begin
          text_buf.push_back(alpha ? 8'h61 + BYTE_W'($urandom_range(0, 2))
                                   : BYTE_W'($urandom_range(0, 255)));
        end
      end

      for (i = 0; i < text_buf.size(); i++) begin
        // Now and then a register changes in mid-text once the output is idle.
        if (i > 0 && $urandom_range(0, 39) == 0) begin
          source_rest();
          wait_drained();
          idx = CFG_IDX_W'($urandom_range(0, 3));
          if (idx == CFG_SEARCH_WORD || idx == CFG_REPLACE_WORD)
            cfg_write(idx, random_word(alpha));
          else if (idx == CFG_SEARCH_LENGTH)
            cfg_write(idx, length_data(random_search_len()));
          else
            cfg_write(idx, length_data(random_replace_len()));
        end
        send_char(text_buf[i], i == text_buf.size() - 1);
        sent++;
      end
      source_rest();
      wait_drained();
    end
  endtask

  // Receiver: random ready gaps, plus a long hold-off on request.
  initial begin : sink
    int unsigned n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = draw_gap(sink_idle);
      if (sink_hold != 0) begin
        n = sink_hold;
        sink_hold = 0;
      end
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1 && sink_hold == 0);
      @(negedge clk);
    end
  end

  // Compare each accepted output word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (rewritten_q.size() == 0) begin
        report_mismatch("output word with none expected", out_byte, '0);
      end else begin
        head_w = rewritten_q.pop_front();
        if (out_byte !== head_w.ch) report_mismatch("out_byte", out_byte, head_w.ch);
        if (byte_valid !== head_w.ch_valid)
          report_mismatch("byte_valid", BYTE_W'(byte_valid), BYTE_W'(head_w.ch_valid));
        if (last !== head_w.fin) report_mismatch("last", BYTE_W'(last), BYTE_W'(head_w.fin));
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    end_of_text = 1'b0;
    m_search_word = '0;
    m_search_len = LEN_W'(1);
    m_replace_word = '0;
    m_replace_len = '0;
    held_bytes = '0;
    held_n = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_basic_replace();
    test_length_limits();
    test_backpressure();
    test_random_texts();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
